### src/i2cpm_pkg.sv
`default_nettype none

package i2cpm_pkg;

  // controller base addresses, 4 KiB aligned
  localparam logic [31:0] BASE_A = 32'h01c2_2000;
  localparam logic [31:0] BASE_B = 32'h01e2_8000;

  // register offsets within one instance window
  localparam logic [11:0] OFF_MODE = 12'h024;
  localparam logic [11:0] OFF_FUNC = 12'h048;
  localparam logic [11:0] OFF_DIR  = 12'h04c;
  localparam logic [11:0] OFF_OUT  = 12'h054;
  localparam logic [11:0] OFF_SET  = 12'h058;
  localparam logic [11:0] OFF_CLR  = 12'h05c;

  // write masks
  localparam logic [31:0] MODE_MASK = 32'h0000_efff;
  localparam logic [31:0] FUNC_MASK = 32'h0000_0001;
  localparam logic [31:0] PIN_MASK  = 32'h0000_0003;

  // reset release bit of mode and the bits allowed with it
  localparam logic [31:0] MODE_RELEASE = 32'h0000_0020;
  localparam logic [31:0] MODE_RELEASE_ALLOWED = 32'h0000_4020;

  localparam logic [3:0] WORD_SIZE = 4'd4;

  typedef struct packed {
    logic        req_type;
    logic [31:0] address;
    logic [31:0] write_data;
    logic        data_too_wide;
    logic [3:0]  access_size;
    logic        commit;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] read_data;
  } rsp_t;

endpackage

`default_nettype wire

### src/i2cpm_if.sv
`default_nettype none

interface i2cpm_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] address;
  logic [31:0] write_data;
  logic        data_too_wide;
  logic [3:0]  access_size;
  logic        commit;

  modport source (
    output valid, req_type, address, write_data, data_too_wide, access_size, commit,
    input  ready
  );
  modport sink (
    input  valid, req_type, address, write_data, data_too_wide, access_size, commit,
    output ready
  );
  modport mon (
    input valid, ready, req_type, address, write_data, data_too_wide, access_size, commit
  );
endinterface

interface i2cpm_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [15:0] read_data;

  modport source (
    output valid, ok, read_data,
    input  ready
  );
  modport sink (
    input  valid, ok, read_data,
    output ready
  );
  modport mon (
    input valid, ready, ok, read_data
  );
endinterface

`default_nettype wire

### src/i2cpm_regfile.sv
`default_nettype none

module i2cpm_regfile (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire i2cpm_pkg::req_t req_i,
  input  wire logic          exec_i,
  output i2cpm_pkg::rsp_t    rsp_o
);
  import i2cpm_pkg::*;

  logic [15:0] mode_q [2];
  logic        func_q [2];
  logic [1:0]  dir_q  [2];
  logic [1:0]  out_q  [2];

  logic        hit_a;
  logic        hit_b;
  logic        mapped;
  logic        inst;
  logic [11:0] off;
  logic [31:0] val;
  logic [31:0] mask;
  logic        rd_ok;
  logic [15:0] rd_data;
  logic        wr_ok;
  logic        wr_en;

  assign hit_a  = (req_i.address[31:12] == BASE_A[31:12]);
  assign hit_b  = (req_i.address[31:12] == BASE_B[31:12]);
  assign mapped = (hit_a || hit_b) && (req_i.address[1:0] == 2'b00);
  assign inst   = hit_b;
  assign off    = req_i.address[11:0];
  assign val    = req_i.write_data;

  // read path
  always_comb begin
    rd_ok   = mapped;
    rd_data = '0;
    unique case (off)
      OFF_MODE: rd_data = mode_q[inst];
      OFF_FUNC: rd_data = {15'd0, func_q[inst]};
      OFF_DIR:  rd_data = {14'd0, dir_q[inst]};
      OFF_OUT:  rd_data = {14'd0, out_q[inst]};
      default: begin
        rd_ok   = 1'b0;
        rd_data = '0;
      end
    endcase
    if (!mapped) begin
      rd_data = '0;
    end
  end

  // write check
  always_comb begin
    wr_ok = mapped && (req_i.access_size == WORD_SIZE) && !req_i.data_too_wide;
    mask  = '0;
    unique case (off)
      OFF_MODE: begin
        if (((val & MODE_RELEASE) != '0) &&
            (!func_q[inst] || ((val & ~MODE_RELEASE_ALLOWED) != '0))) begin
          wr_ok = 1'b0;
        end
        mask = MODE_MASK;
      end
      OFF_FUNC: begin
        if (mode_q[inst][5] && (val != {31'd0, func_q[inst]})) begin
          wr_ok = 1'b0;
        end
        mask = FUNC_MASK;
      end
      OFF_DIR, OFF_OUT, OFF_SET, OFF_CLR: mask = PIN_MASK;
      default: wr_ok = 1'b0;
    endcase
    if ((val & ~mask) != '0) begin
      wr_ok = 1'b0;
    end
  end

  assign wr_en = exec_i && req_i.req_type && wr_ok && req_i.commit;

  always_comb begin
    if (req_i.req_type) begin
      rsp_o.ok        = wr_ok;
      rsp_o.read_data = '0;
    end else begin
      rsp_o.ok        = rd_ok;
      rsp_o.read_data = rd_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        mode_q[i] <= '0;
        func_q[i] <= 1'b0;
        dir_q[i]  <= '0;
        out_q[i]  <= '0;
      end
    end else if (wr_en) begin
      unique case (off)
        OFF_MODE: mode_q[inst] <= val[15:0];
        OFF_FUNC: func_q[inst] <= val[0];
        OFF_DIR:  dir_q[inst]  <= val[1:0];
        OFF_OUT:  out_q[inst]  <= val[1:0];
        OFF_SET:  out_q[inst]  <= out_q[inst] | val[1:0];
        OFF_CLR:  out_q[inst]  <= out_q[inst] & ~val[1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/i2c_pin_mode_register_bank.sv
// a transfer accepted into the request register moves on to the result register when the
//   result register is free; the request register and result register part the two sides
// throughput: one access per cycle, sustained, limited only by the result consumer
// reset: rst_ni is asynchronous and active low; it empties both stages and clears
//   mode, function, direction and output of both instances to zero
`default_nettype none

module i2c_pin_mode_register_bank (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  i2cpm_req_if.sink     req_i,
  i2cpm_rsp_if.source   rsp_o
);
  import i2cpm_pkg::*;

  // request stage
  logic  in_vld_q;
  req_t  in_q;
  req_t  in_d;

  // result stage
  logic  res_vld_q;
  rsp_t  res_q;
  rsp_t  res_d;

  logic  in_fire;
  logic  advance;

  // the request stage moves on whenever the result register is empty or being drained
  assign advance     = in_vld_q && (!res_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || advance;
  assign in_fire     = req_i.valid && req_i.ready;

  always_comb begin
    in_d.req_type      = req_i.req_type;
    in_d.address       = req_i.address;
    in_d.write_data    = req_i.write_data;
    in_d.data_too_wide = req_i.data_too_wide;
    in_d.access_size   = req_i.access_size;
    in_d.commit        = req_i.commit;
  end

  // decode, check, read mux and state update for the held request;
  // the update commits on the same edge that loads the result register
  i2cpm_regfile u_regfile (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_q),
    .exec_i (advance),
    .rsp_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign rsp_o.valid     = res_vld_q;
  assign rsp_o.ok        = res_q.ok;
  assign rsp_o.read_data = res_q.read_data;

endmodule

`default_nettype wire

### src/i2cpm_checker.sv
`default_nettype none

module i2cpm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        req_valid_i,
  input wire logic        req_ready_i,
  input wire logic        rsp_valid_i,
  input wire logic        rsp_ready_i,
  input wire logic        rsp_ok_i,
  input wire logic [15:0] rsp_data_i
);

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !rsp_valid_i)
    else $error("result valid during reset");

  // rejected accesses never carry read data
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ok_i) |-> (rsp_data_i == 16'd0))
    else $error("rejected access returned data");

  // two-deep buffering: a transfer taken while the result stalls fills the request
  // stage, so a continued stall must block input
  a_two_deep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(rsp_valid_i && !rsp_ready_i && req_valid_i && req_ready_i) &&
     rsp_valid_i && !rsp_ready_i) |-> !req_ready_i)
    else $error("input accepted beyond buffer depth");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(rsp_ok_i) && $stable(rsp_data_i)))
    else $error("stalled result changed");

endmodule

bind i2c_pin_mode_register_bank i2cpm_checker u_i2cpm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_ok_i    (rsp_o.ok),
  .rsp_data_i  (rsp_o.read_data)
);

`default_nettype wire

### sim/tb.sv
`default_nettype none

module tb;
  import i2cpm_pkg::*;

  // access kinds on the request channel
  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  localparam int RAND_PER_PHASE = 475;  // four phases, about 1900 random accesses
  localparam int HOLD_CYCLES    = 400;  // long consumer hold-off to back the block up
  localparam int DRAIN_CYCLES   = 12;   // settling wait once nothing is pending
  localparam int LIMIT_CYCLES   = 200000;

  // one directed stimulus row; want is only used where typed is set
  typedef struct {
    req_t acc;
    bit   typed;
    rsp_t want;
  } access_row_t;

  logic clk_i;
  logic rst_ni;

  i2cpm_req_if req_bus ();
  i2cpm_rsp_if rsp_bus ();

  i2c_pin_mode_register_bank dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // shadow copy of the per-instance registers
  logic [15:0] mode_q [2];
  logic        func_q [2];
  logic [1:0]  dir_q  [2];
  logic [1:0]  out_q  [2];

  rsp_t        pending_rsp [$];
  access_row_t directed_rows [$];

  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned cycle_count;
  int unsigned reads_sent, writes_sent, accepted_cnt, release_cnt;

  // idling knobs, set per phase by the main sequence
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_pending;
  int unsigned hold_left;

  // clock, 12 time units per period
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // every block input known from time zero
  initial begin
    rst_ni                = 1'b0;
    req_bus.valid         = 1'b0;
    req_bus.req_type      = ACC_READ;
    req_bus.address       = '0;
    req_bus.write_data    = '0;
    req_bus.data_too_wide = 1'b0;
    req_bus.access_size   = '0;
    req_bus.commit        = 1'b0;
    rsp_bus.ready         = 1'b0;
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_rsp.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
             results_seen, what, got, want);
    mismatches++;
  endtask

  // register bank behavior: decode, access checks, state update on commit
  function automatic rsp_t predict_access(req_t a);
    rsp_t        r;
    logic [31:0] base;
    logic [11:0] off;
    logic [31:0] mask;
    logic        hit;
    logic        acc;
    int unsigned inst;
    r    = '0;
    base = {a.address[31:12], 12'h000};
    off  = a.address[11:0];
    hit  = (base == BASE_A || base == BASE_B) && (a.address[1:0] == 2'b00);
    inst = (base == BASE_B) ? 1 : 0;
    mask = '0;
    if (a.req_type == ACC_READ) begin
      reads_sent++;
      if (hit) begin
        r.ok = 1'b1;
        case (off)
          OFF_MODE: r.read_data = mode_q[inst];
          OFF_FUNC: r.read_data = {15'b0, func_q[inst]};
          OFF_DIR:  r.read_data = {14'b0, dir_q[inst]};
          OFF_OUT:  r.read_data = {14'b0, out_q[inst]};
          default:  r = '0;  // set, clear and unknown offsets are not readable
        endcase
      end
    end else begin
      writes_sent++;
      if (a.access_size == WORD_SIZE && !a.data_too_wide && hit) begin
        acc = 1'b1;
        case (off)
          OFF_MODE: begin
            // leaving reset needs the pin function and nothing but the allowed bits
            if ((a.write_data & MODE_RELEASE) != 0 &&
                (func_q[inst] != 1'b1 || (a.write_data & ~MODE_RELEASE_ALLOWED) != 0))
              acc = 1'b0;
            mask = MODE_MASK;
          end
          OFF_FUNC: begin
            // function is frozen while the instance is out of reset
            if ((mode_q[inst] & MODE_RELEASE[15:0]) != 0 &&
                a.write_data != {31'b0, func_q[inst]})
              acc = 1'b0;
            mask = FUNC_MASK;
          end
          OFF_DIR, OFF_OUT, OFF_SET, OFF_CLR: mask = PIN_MASK;
          default: acc = 1'b0;
        endcase
        if (acc && (a.write_data & ~mask) != 0)
          acc = 1'b0;
        if (acc && a.commit) begin
          case (off)
            OFF_MODE: begin
              mode_q[inst] = a.write_data[15:0];
              if ((a.write_data & MODE_RELEASE) != 0)
                release_cnt++;
            end
            OFF_FUNC: func_q[inst] = a.write_data[0];
            OFF_DIR:  dir_q[inst]  = a.write_data[1:0];
            OFF_OUT:  out_q[inst]  = a.write_data[1:0];
            OFF_SET:  out_q[inst]  = out_q[inst] | a.write_data[1:0];
            OFF_CLR:  out_q[inst]  = out_q[inst] & ~a.write_data[1:0];
            default: ;
          endcase
        end
        r.ok = acc;
      end
    end
    if (r.ok)
      accepted_cnt++;
    return r;
  endfunction

  function automatic req_t make_req(logic rt, logic [31:0] addr, logic [31:0] data,
                                    logic wide, logic [3:0] size, logic cmt);
    req_t a;
    a.req_type      = rt;
    a.address       = addr;
    a.write_data    = data;
    a.data_too_wide = wide;
    a.access_size   = size;
    a.commit        = cmt;
    return a;
  endfunction

  task automatic add_row(logic rt, logic [31:0] addr, logic [31:0] data, logic wide,
                         logic [3:0] size, logic cmt, bit typed, logic ok,
                         logic [15:0] rd);
    access_row_t row;
    row.acc  = make_req(rt, addr, data, wide, size, cmt);
    row.typed = typed;
    row.want = '{ok: ok, read_data: rd};
    directed_rows.push_back(row);
  endtask

  // random access, mostly well-formed register traffic with some noise
  function automatic req_t make_random_access();
    req_t        a;
    logic [31:0] base;
    logic [11:0] off;
    int unsigned pick;
    base = $urandom_range(0, 1) ? BASE_B : BASE_A;
    pick = $urandom_range(0, 5);
    case (pick)
      0: off = OFF_MODE;
      1: off = OFF_FUNC;
      2: off = OFF_DIR;
      3: off = OFF_OUT;
      4: off = OFF_SET;
      default: off = OFF_CLR;
    endcase
    a.req_type = $urandom_range(0, 1) ? ACC_WRITE : ACC_READ;
    pick = $urandom_range(0, 99);
    if (pick < 80)
      a.address = base | off;
    else if (pick < 88)
      a.address = base | ($urandom & 32'h0000_0ffc);
    else if (pick < 92)
      a.address = base | off | $urandom_range(1, 3);
    else if (pick < 96)
      a.address = base ^ (32'h1 << $urandom_range(12, 31));
    else
      a.address = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 40)
      a.write_data = $urandom_range(0, 3);
    else if (pick < 55)
      a.write_data = $urandom_range(0, 1) ? MODE_RELEASE_ALLOWED : MODE_RELEASE;
    else if (pick < 75)
      a.write_data = $urandom & MODE_MASK;
    else if (pick < 85)
      a.write_data = $urandom & MODE_MASK & ~MODE_RELEASE;
    else
      a.write_data = $urandom;
    a.data_too_wide = ($urandom_range(0, 99) < 5);
    a.access_size   = ($urandom_range(0, 99) < 90) ? WORD_SIZE : 4'($urandom_range(0, 8));
    a.commit        = ($urandom_range(0, 99) < 85);
    return a;
  endfunction

  // offer one access, hold it until the transfer, then record what should come back
  task automatic send_access(req_t a, bit typed, rsp_t want);
    rsp_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk_i);
      req_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    req_bus.valid         <= 1'b1;
    req_bus.req_type      <= a.req_type;
    req_bus.address       <= a.address;
    req_bus.write_data    <= a.write_data;
    req_bus.data_too_wide <= a.data_too_wide;
    req_bus.access_size   <= a.access_size;
    req_bus.commit        <= a.commit;
    do @(posedge clk_i); while (!req_bus.ready);
    // the predictor always runs so that its state follows the block
    predicted = predict_access(a);
    pending_rsp.push_back(typed ? want : predicted);
  endtask

  // result consumer: random stalls, plus a long hold-off when asked for
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk_i) begin : check_results
    rsp_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("result with nothing pending", {15'b0, rsp_bus.ok, rsp_bus.read_data},
                        32'h0);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_bus.ok !== want.ok)
          report_mismatch("ok", 32'(rsp_bus.ok), 32'(want.ok));
        if (rsp_bus.read_data !== want.read_data)
          report_mismatch("read_data", 32'(rsp_bus.read_data), 32'(want.read_data));
      end
      results_seen++;
    end
  end

  initial begin : main_seq
    int unsigned phase;
    int unsigned idx;
    for (int i = 0; i < 2; i++) begin
      mode_q[i] = '0;
      func_q[i] = 1'b0;
      dir_q[i]  = '0;
      out_q[i]  = '0;
    end
    mismatches     = 0;
    results_seen   = 0;
    cycle_count    = 0;
    reads_sent     = 0;
    writes_sent    = 0;
    accepted_cnt   = 0;
    release_cnt    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_pending   = 1'b0;
    hold_left      = 0;

    // directed rows: reset values, decode misses, access checks, reset release rules
    add_row(ACC_READ,  BASE_A | OFF_MODE, 32'h0, 1'b0, 4'd0, 1'b0, 1, 1'b1, 16'h0);
    add_row(ACC_READ,  BASE_B | OFF_FUNC, 32'hffff_ffff, 1'b1, 4'd8, 1'b1, 1, 1'b1, 16'h0);
    add_row(ACC_READ,  BASE_A | OFF_SET, 32'h0, 1'b0, 4'd4, 1'b0, 1, 1'b0, 16'h0);
    add_row(ACC_READ,  BASE_B | OFF_CLR, 32'h0, 1'b0, 4'd4, 1'b0, 1, 1'b0, 16'h0);
    add_row(ACC_READ,  32'h0000_0000, 32'h0, 1'b0, 4'd4, 1'b0, 1, 1'b0, 16'h0);
    add_row(ACC_READ,  32'hffff_ffff, 32'h0, 1'b0, 4'd4, 1'b0, 1, 1'b0, 16'h0);
    add_row(ACC_READ,  BASE_A | 32'h025, 32'h0, 1'b0, 4'd4, 1'b0, 1, 1'b0, 16'h0);
    add_row(ACC_WRITE, BASE_A | OFF_DIR, 32'h1, 1'b0, 4'd2, 1'b1, 1, 1'b0, 16'h0);
    add_row(ACC_WRITE, BASE_A | OFF_DIR, 32'h1, 1'b0, 4'd8, 1'b1, 1, 1'b0, 16'h0);
    add_row(ACC_WRITE, BASE_A | OFF_DIR, 32'h1, 1'b1, 4'd4, 1'b1, 1, 1'b0, 16'h0);
    add_row(ACC_WRITE, BASE_A | OFF_DIR, 32'hffff_ffff, 1'b0, 4'd4, 1'b1, 1, 1'b0, 16'h0);
    add_row(ACC_WRITE, BASE_B | 32'h030, 32'h0, 1'b0, 4'd4, 1'b1, 1, 1'b0, 16'h0);
    add_row(ACC_WRITE, BASE_A | OFF_DIR, 32'h3, 1'b0, 4'd4, 1'b1, 0, 1'b0, 16'h0);
    add_row(ACC_WRITE, BASE_A | OFF_OUT, 32'h3, 1'b0, 4'd4, 1'b0, 0, 1'b0, 16'h0);
    add_row(ACC_WRITE, BASE_A | OFF_OUT, 32'h2, 1'b0, 4'd4, 1'b1, 0, 1'b0, 16'h0);
    add_row(ACC_WRITE, BASE_A | OFF_SET, 32'h1, 1'b0, 4'd4, 1'b1, 0, 1'b0, 16'h0);
    add_row(ACC_WRITE, BASE_A | OFF_CLR, 32'h2, 1'b0, 4'd4, 1'b1, 0, 1'b0, 16'h0);
    add_row(ACC_READ,  BASE_A | OFF_OUT, 32'h0, 1'b0, 4'd0, 1'b0, 0, 1'b0, 16'h0);
    add_row(ACC_WRITE, BASE_A | OFF_MODE, 32'h20, 1'b0, 4'd4, 1'b1, 1, 1'b0, 16'h0);
    add_row(ACC_WRITE, BASE_A | OFF_FUNC, 32'h1, 1'b0, 4'd4, 1'b1, 0, 1'b0, 16'h0);
    add_row(ACC_WRITE, BASE_A | OFF_MODE, 32'h4021, 1'b0, 4'd4, 1'b1, 1, 1'b0, 16'h0);
    add_row(ACC_WRITE, BASE_A | OFF_MODE, 32'h4020, 1'b0, 4'd4, 1'b1, 0, 1'b0, 16'h0);
    add_row(ACC_WRITE, BASE_A | OFF_FUNC, 32'h0, 1'b0, 4'd4, 1'b1, 0, 1'b0, 16'h0);
    add_row(ACC_WRITE, BASE_A | OFF_FUNC, 32'h1, 1'b0, 4'd4, 1'b1, 0, 1'b0, 16'h0);
    add_row(ACC_WRITE, BASE_B | OFF_MODE, 32'hf000, 1'b0, 4'd4, 1'b1, 1, 1'b0, 16'h0);
    add_row(ACC_WRITE, BASE_A | OFF_MODE, 32'hefdf, 1'b0, 4'd4, 1'b1, 0, 1'b0, 16'h0);
    add_row(ACC_READ,  BASE_A | OFF_MODE, 32'h0, 1'b0, 4'd4, 1'b0, 0, 1'b0, 16'h0);

    // reset held, then released away from the rising edge
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i])
      send_access(directed_rows[i].acc, directed_rows[i].typed, directed_rows[i].want);

    // phases: no idling, idle sender, stalling consumer, both a little
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      // consumer goes quiet while the sender keeps offering, so the input stalls
      if (phase == 0)
        hold_pending = 1'b1;
      for (idx = 0; idx < RAND_PER_PHASE; idx++)
        send_access(make_random_access(), 0, '0);
    end
    @(negedge clk_i);
    req_bus.valid <= 1'b0;

    while (pending_rsp.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d reads and %0d writes on both instances, %0d accepted",
             reads_sent, writes_sent, accepted_cnt);
    $display("%0d results checked, %0d committed reset releases, %0d mismatches",
             results_seen, release_cnt, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
